[rtl/core/rar_pkg.sv]
// Shared constants and types for the rational arithmetic reduction block.
`timescale 1ns / 1ps
`default_nettype none

package rar_pkg;

    // Default operand width of each fraction part
    localparam int IN_WIDTH_DEF = 16;

    // Operation selector carried on the input tuser
    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    // Handshake between the sequencer and the shared divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/core/rar_mul.sv]
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module rar_mul #(
    parameter int IN_WIDTH = rar_pkg::IN_WIDTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic signed [IN_WIDTH-1:0]  op_a,
    input  wire logic signed [IN_WIDTH-1:0]  op_b,
    output logic signed [2*IN_WIDTH-1:0]     prod
);

    logic signed [2*IN_WIDTH-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/core/rar_div.sv]
// Shared restoring divider on unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rar_div #(
    parameter int W = 2 * rar_pkg::IN_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rar_pkg::div_ctrl_t ctrl,
    input  wire logic [W-1:0]      dividend,
    input  wire logic [W-1:0]      divisor,
    output logic [W-1:0]           quotient,
    output logic [W-1:0]           remainder,
    output rar_pkg::div_stat_t     stat
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     pr_reg;
    logic [W-1:0]     quo_reg;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0]       shifted;
    logic [W+1:0]     diff;
    logic             ge;

    assign shifted = {pr_reg, quo_reg[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};
    assign ge      = ~diff[W+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            pr_reg  <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            // keep the trial difference when it does not borrow
            pr_reg  <= ge ? diff[W-1:0] : shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign quotient   = quo_reg;
    assign remainder  = pr_reg;
    assign stat.done  = done_reg;

endmodule

`default_nettype wire

[rtl/core/rational_arith_reduce.sv]
// Top level: fraction arithmetic with gcd reduction on a shared multiplier and divider.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tdata: num_a, den_a, num_b, den_b; tuser: kind
//  m_      | out | m_tvalid/m_tready  | tdata: res_num, res_den; tuser: zero_gcd
//
//  Each item runs its Euclidean steps on the bit-serial divider, then divides the numerator
//  and the denominator by the gcd; the bit-serial divider sets how long an item takes.
//  Cross products go through one multiplier, one operand pair per step.
//  Reset is synchronous, active low; s_tready is high only while no item is in work.
//  A finished result waits in the output register; the next item may be taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module rational_arith_reduce #(
    parameter int IN_WIDTH = rar_pkg::IN_WIDTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // num_a, den_a, num_b, den_b from bit 0 up
    input  wire logic [((4*IN_WIDTH+7)/8)*8-1:0]       s_tdata,
    // kind
    input  wire logic [1:0]                            s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // res_num, res_den from bit 0 up, zero padded
    output logic [((2*(2*IN_WIDTH+1)+7)/8)*8-1:0]      m_tdata,
    // zero_gcd
    output logic [0:0]                                 m_tuser
);

    localparam int RES_WIDTH = 2 * IN_WIDTH + 1;
    localparam int MAG_W     = 2 * IN_WIDTH;
    localparam int M_DATA_W  = ((2 * RES_WIDTH + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EUC,
        ST_REM,
        ST_QN,
        ST_QD,
        ST_OUT
    } state_t;

    function automatic logic [MAG_W-1:0] mag(input logic signed [RES_WIDTH-1:0] x);
        logic signed [RES_WIDTH-1:0] a;
        a = x[RES_WIDTH-1] ? -x : x;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic signed [RES_WIDTH-1:0] signed_of(input logic neg,
                                                             input logic [MAG_W-1:0] m);
        logic signed [RES_WIDTH-1:0] a;
        a = $signed({1'b0, m});
        return neg ? -a : a;
    endfunction

    state_t                         state_reg, state_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]            m_tdata_reg, m_tdata_next;
    logic                           m_tuser_reg, m_tuser_next;
    logic                           zero_reg, zero_next;

    rar_pkg::kind_t                 kind_reg;
    logic signed [IN_WIDTH-1:0]     na_reg, da_reg, nb_reg, db_reg;
    logic [1:0]                     step_reg;
    logic signed [MAG_W-1:0]        p0_reg, p1_reg;
    logic signed [RES_WIDTH-1:0]    n_reg, d_reg, m_reg, k_reg, qn_reg, qd_reg;

    logic signed [IN_WIDTH-1:0]     mul_a, mul_b;
    logic signed [MAG_W-1:0]        prod;
    logic signed [RES_WIDTH-1:0]    p0x, p1x, prodx, n_raw;

    rar_pkg::div_ctrl_t             div_ctrl;
    rar_pkg::div_stat_t             div_stat;
    logic [MAG_W-1:0]               div_dvd, div_dsr, div_quo, div_rem;

    logic                           out_free;
    logic                           s_accept;

    rar_mul #(.IN_WIDTH(IN_WIDTH)) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    rar_div #(.W(MAG_W)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (div_dvd),
        .divisor   (div_dsr),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // operand pairs: step 0 first product, step 1 da*nb, step 2 denominator
    always_comb begin
        case (step_reg)
            2'd0: begin
                mul_a = na_reg;
                mul_b = (kind_reg == rar_pkg::KIND_MUL) ? nb_reg : db_reg;
            end
            2'd1: begin
                mul_a = da_reg;
                mul_b = nb_reg;
            end
            default: begin
                mul_a = da_reg;
                mul_b = (kind_reg == rar_pkg::KIND_DIV) ? nb_reg : db_reg;
            end
        endcase
    end

    assign p0x   = RES_WIDTH'(p0_reg);
    assign p1x   = RES_WIDTH'(p1_reg);
    assign prodx = RES_WIDTH'(prod);

    always_comb begin
        case (kind_reg)
            rar_pkg::KIND_ADD: n_raw = p0x + p1x;
            rar_pkg::KIND_SUB: n_raw = p0x - p1x;
            default:           n_raw = p0x;
        endcase
    end

    // divider requests
    always_comb begin
        div_ctrl.start = 1'b0;
        div_dvd        = mag(m_reg);
        div_dsr        = mag(k_reg);
        case (state_reg)
            ST_EUC: begin
                if (k_reg != '0) begin
                    div_ctrl.start = 1'b1;
                end else if (m_reg != '0) begin
                    div_ctrl.start = 1'b1;
                    div_dvd        = mag(n_reg);
                    div_dsr        = mag(m_reg);
                end
            end
            ST_QN: begin
                div_dvd        = mag(d_reg);
                div_dsr        = mag(m_reg);
                div_ctrl.start = div_stat.done;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        zero_next     = zero_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                if (step_reg == 2'd3) begin
                    state_next = ST_EUC;
                end
            end
            ST_EUC: begin
                if (k_reg != '0) begin
                    state_next = ST_REM;
                end else if (m_reg != '0) begin
                    state_next = ST_QN;
                    zero_next  = 1'b0;
                end else begin
                    state_next = ST_OUT;
                    zero_next  = 1'b1;
                end
            end
            ST_REM: begin
                if (div_stat.done) begin
                    state_next = ST_EUC;
                end
            end
            ST_QN: begin
                if (div_stat.done) begin
                    state_next = ST_QD;
                end
            end
            ST_QD: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = zero_reg ? '0 : M_DATA_W'({qd_reg, qn_reg});
                    m_tuser_next  = zero_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tuser_reg  <= 1'b0;
            zero_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tuser_reg  <= m_tuser_next;
            zero_reg     <= zero_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            kind_reg <= rar_pkg::kind_t'(s_tuser);
            na_reg   <= s_tdata[IN_WIDTH-1:0];
            da_reg   <= s_tdata[2*IN_WIDTH-1:IN_WIDTH];
            nb_reg   <= s_tdata[3*IN_WIDTH-1:2*IN_WIDTH];
            db_reg   <= s_tdata[4*IN_WIDTH-1:3*IN_WIDTH];
            step_reg <= 2'd0;
        end
        case (state_reg)
            ST_MUL: begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd1) begin
                    p0_reg <= prod;
                end
                if (step_reg == 2'd2) begin
                    p1_reg <= prod;
                end
                if (step_reg == 2'd3) begin
                    n_reg <= n_raw;
                    d_reg <= prodx;
                    m_reg <= n_raw;
                    k_reg <= prodx;
                end
            end
            ST_REM: begin
                // remainder takes the sign of the dividend
                if (div_stat.done) begin
                    m_reg <= k_reg;
                    k_reg <= signed_of(m_reg[RES_WIDTH-1], div_rem);
                end
            end
            ST_QN: begin
                if (div_stat.done) begin
                    qn_reg <= signed_of(n_reg[RES_WIDTH-1] ^ m_reg[RES_WIDTH-1], div_quo);
                end
            end
            ST_QD: begin
                if (div_stat.done) begin
                    qd_reg <= signed_of(d_reg[RES_WIDTH-1] ^ m_reg[RES_WIDTH-1], div_quo);
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire

[rtl/core/rar_checker.sv]
// Port-level checks for the rational arithmetic reduction block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rar_checker #(
    parameter int IN_WIDTH = rar_pkg::IN_WIDTH_DEF
) (
    input wire logic                                  aclk,
    input wire logic                                  aresetn,
    input wire logic                                  s_tvalid,
    input wire logic                                  s_tready,
    input wire logic                                  m_tvalid,
    input wire logic                                  m_tready,
    input wire logic [((2*(2*IN_WIDTH+1)+7)/8)*8-1:0] m_tdata,
    input wire logic [0:0]                            m_tuser
);

    localparam int RES_WIDTH = 2 * IN_WIDTH + 1;

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // zero gcd gives zero fields
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("zero gcd with nonzero result");

    // a reduced result never has both parts zero
    a_nonzero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |->
            (m_tdata[RES_WIDTH-1:0] != '0) || (m_tdata[2*RES_WIDTH-1:RES_WIDTH] != '0))
        else $error("reduced result with both parts zero");

endmodule

bind rational_arith_reduce rar_checker #(.IN_WIDTH(IN_WIDTH)) u_rar_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
